// File: hw/rtl/rbpi_pkg.sv
// ----------------------------------------------------------------------------
// Build-plane ray intersect package
// Widths, payload types and register indexes shared by the pipeline.
// ----------------------------------------------------------------------------
package rbpi_pkg;

    localparam int CW    = 32;            // coordinate width
    localparam int LW    = 8;             // layer width
    localparam int GW    = 31;            // grid size width
    localparam int YW    = LW + GW;       // plane y (signed) and |v_y|
    localparam int HW    = YW - CW;       // upper part of |v_y|
    localparam int SW    = 2 * YW + 2;    // squared length
    localparam int PW    = CW + YW + 2;   // dot sums, ratio terms
    localparam int RW    = PW + 2;        // divider partial remainder
    localparam int NSTEP = CW;            // one quotient step per |d| bit
    localparam int NPRE  = 7;             // stages ahead of the divider
    localparam int NST   = NPRE + NSTEP;
    localparam int AW    = 2;

    localparam logic [AW-1:0] REG_SCENE_READY = AW'(0);
    localparam logic [AW-1:0] REG_GRID_SIZE   = AW'(1);
    localparam logic [AW-1:0] REG_ANCHOR_X    = AW'(2);
    localparam logic [AW-1:0] REG_ANCHOR_Z    = AW'(3);

    localparam logic [GW-1:0] GRID_SIZE_RST = GW'(65536);

    typedef struct packed {
        logic signed [CW-1:0] ray_from_x;
        logic signed [CW-1:0] ray_from_y;
        logic signed [CW-1:0] ray_from_z;
        logic signed [CW-1:0] ray_to_x;
        logic signed [CW-1:0] ray_to_y;
        logic signed [CW-1:0] ray_to_z;
        logic signed [LW-1:0] grid_layer;
    } t_ray;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] pos_z;
    } t_res;

    typedef struct packed {
        logic [AW-1:0] idx;
        logic [CW-1:0] wdata;
    } t_cfg;

    typedef struct packed {
        logic                  ok;
        logic [PW-1:0]         nn;
        logic [PW-1:0]         dd;
        logic [2:0][CW-1:0]    f;
        logic [2:0][CW-1:0]    dm;
        logic [2:0]            dn;
    } t_scl_in;

    typedef struct packed {
        logic                  ok;
        logic [PW-1:0]         nn;
        logic [PW-1:0]         dd;
        logic [2:0][CW-1:0]    f;
        logic [2:0][CW-1:0]    dm;
        logic [2:0]            dn;
        logic [2:0][CW-1:0]    q;
        logic [2:0][PW-1:0]    rem;
    } t_scl_st;

endpackage

// File: hw/rtl/rbpi_if.sv
// ----------------------------------------------------------------------------
// Build-plane ray intersect channels
// Valid/ready channels for rays, results and register writes.
// ----------------------------------------------------------------------------
interface rbpi_ray_if;
    logic              valid;
    logic              ready;
    rbpi_pkg::t_ray    data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rbpi_res_if;
    logic              valid;
    logic              ready;
    rbpi_pkg::t_res    data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rbpi_cfg_if;
    logic              valid;
    logic              ready;
    rbpi_pkg::t_cfg    data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/rbpi_scale.sv
// ----------------------------------------------------------------------------
// Build-plane ray intersect scaler
// Pipelined |d| * nn / dd for three axes, one |d| bit per stage.
// ----------------------------------------------------------------------------
module rbpi_scale (
    input  logic                          i_clk,
    input  logic [rbpi_pkg::NSTEP-1:0]    i_en,
    input  rbpi_pkg::t_scl_in             i_d,
    output rbpi_pkg::t_scl_st             o_st
);

    rbpi_pkg::t_scl_st r_st [rbpi_pkg::NSTEP];

    for (genvar k = 0; k < rbpi_pkg::NSTEP; k++) begin : g_step
        rbpi_pkg::t_scl_st s_prv;
        rbpi_pkg::t_scl_st n_st;

        if (k == 0) begin : g_first
            always_comb begin
                s_prv     = '0;
                s_prv.ok  = i_d.ok;
                s_prv.nn  = i_d.nn;
                s_prv.dd  = i_d.dd;
                s_prv.f   = i_d.f;
                s_prv.dm  = i_d.dm;
                s_prv.dn  = i_d.dn;
            end
        end else begin : g_next
            assign s_prv = r_st[k-1];
        end

        always_comb begin
            logic [rbpi_pkg::RW-1:0] t;
            logic [rbpi_pkg::RW-1:0] d1;
            logic [rbpi_pkg::RW-1:0] d2;
            logic [1:0]              qb;
            n_st = s_prv;
            d1   = rbpi_pkg::RW'(s_prv.dd);
            d2   = d1 << 1;
            for (int j = 0; j < 3; j++) begin
                t = {1'b0, s_prv.rem[j], 1'b0};
                if (s_prv.dm[j][rbpi_pkg::CW-1-k]) begin
                    t = t + rbpi_pkg::RW'(s_prv.nn);
                end
                if (t >= d2) begin
                    t  = t - d2;
                    qb = 2'd2;
                end else if (t >= d1) begin
                    t  = t - d1;
                    qb = 2'd1;
                end else begin
                    qb = 2'd0;
                end
                n_st.rem[j] = t[rbpi_pkg::PW-1:0];
                n_st.q[j]   = {s_prv.q[j][rbpi_pkg::CW-2:0], 1'b0} + rbpi_pkg::CW'(qb);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_st = r_st[rbpi_pkg::NSTEP-1];

endmodule

// File: hw/rtl/ray_build_plane_intersect_top.sv
// ----------------------------------------------------------------------------
// Build-plane ray intersect
// Segment / layer-plane intersection with anchor-plane fallback, Q16.16.
//
//   channel   dir   payload
//   i_ray     in    segment start, end, grid layer
//   o_res     out   hit flag, placement point
//   i_cfg     in    register index, write data
//
// One item per cycle while o_res.ready does not stall the pipeline: 7 setup stages
// (deltas, squares, dot sums, plane selection), 32 divider steps, one rounding stage.
// Reset clears valid bits and config registers; config writes always accepted.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and o_res.ready stalls nothing that has free room.
// ----------------------------------------------------------------------------
module ray_build_plane_intersect_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rbpi_ray_if.sink      i_ray,
    rbpi_cfg_if.sink      i_cfg,
    rbpi_res_if.source    o_res
);

    localparam int CW  = rbpi_pkg::CW;
    localparam int YW  = rbpi_pkg::YW;
    localparam int SW  = rbpi_pkg::SW;
    localparam int PW  = rbpi_pkg::PW;
    localparam int HW  = rbpi_pkg::HW;
    localparam int NST = rbpi_pkg::NST;

    typedef struct packed {
        logic [2:0][CW-1:0] f;
        logic [2:0][CW-1:0] dm;
        logic [2:0]         dn;
        logic [2:0]         cr;
        logic [YW-1:0]      nm;
        logic               pok;
    } t_car;

    // config
    logic                       r_scene_ready;
    logic [rbpi_pkg::GW-1:0]    r_grid_size;
    logic [CW-1:0]              r_anchor_x;
    logic [CW-1:0]              r_anchor_z;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scene_ready <= 1'b0;
            r_grid_size   <= rbpi_pkg::GRID_SIZE_RST;
            r_anchor_x    <= '0;
            r_anchor_z    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.idx)
                rbpi_pkg::REG_SCENE_READY: r_scene_ready <= i_cfg.data.wdata[0];
                rbpi_pkg::REG_GRID_SIZE:   r_grid_size   <= i_cfg.data.wdata[rbpi_pkg::GW-1:0];
                rbpi_pkg::REG_ANCHOR_X:    r_anchor_x    <= i_cfg.data.wdata;
                rbpi_pkg::REG_ANCHOR_Z:    r_anchor_z    <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // flow control
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST-1:0] en;
    logic           en_out;
    logic           r_ovld;

    assign en_out = !r_ovld || o_res.ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        if (k == NST - 1) begin : g_last
            assign en[k] = !r_vld[k] || en_out;
        end else begin : g_mid
            assign en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign n_vld       = {r_vld[NST-2:0], i_ray.valid};
    assign i_ray.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
            if (en_out) begin
                r_ovld <= r_vld[NST-1];
            end
        end
    end

    // stage 1: deltas, plane height
    logic [2:0][CW-1:0]   s_from;
    logic [2:0][CW-1:0]   s_to;
    logic signed [YW:0]   s_py;
    logic [2:0][CW-1:0]   r1_f;
    logic [2:0][CW:0]     r1_d;
    logic [YW-1:0]        r1_py;

    assign s_from = {i_ray.data.ray_from_z, i_ray.data.ray_from_y, i_ray.data.ray_from_x};
    assign s_to   = {i_ray.data.ray_to_z, i_ray.data.ray_to_y, i_ray.data.ray_to_x};
    assign s_py   = $signed(i_ray.data.grid_layer) * $signed({1'b0, r_grid_size});

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_f  <= s_from;
            r1_py <= s_py[YW-1:0];
            for (int j = 0; j < 3; j++) begin
                r1_d[j] <= {s_to[j][CW-1], s_to[j]} - {s_from[j][CW-1], s_from[j]};
            end
        end
    end

    // stage 2: magnitudes and signs
    logic [YW:0]          s2_num;
    logic [YW:0]          s2_nmag;
    logic [CW:0]          s2_vx;
    logic [CW:0]          s2_vz;
    logic [CW:0]          s2_vxm;
    logic [CW:0]          s2_vzm;
    logic                 s2_vyneg;
    logic [2:0][CW-1:0]   s2_dm;
    logic [CW:0]          s2_dabs;

    logic [2:0][CW-1:0]   r2_f;
    logic [2:0][CW-1:0]   r2_dm;
    logic [2:0]           r2_dn;
    logic [2:0]           r2_cr;
    logic [CW-1:0]        r2_vmx;
    logic [CW-1:0]        r2_vmz;
    logic [YW-1:0]        r2_vmy;
    logic [YW-1:0]        r2_nm;
    logic                 r2_nneg;
    logic                 r2_nzero;

    always_comb begin
        s2_num   = {r1_py[YW-1], r1_py} - {{(YW+1-CW){r1_f[1][CW-1]}}, r1_f[1]};
        s2_nmag  = s2_num[YW] ? -s2_num : s2_num;
        s2_vx    = {r1_f[0][CW-1], r1_f[0]} - {r_anchor_x[CW-1], r_anchor_x};
        s2_vz    = {r1_f[2][CW-1], r1_f[2]} - {r_anchor_z[CW-1], r_anchor_z};
        s2_vxm   = s2_vx[CW] ? -s2_vx : s2_vx;
        s2_vzm   = s2_vz[CW] ? -s2_vz : s2_vz;
        s2_vyneg = !s2_num[YW] && (s2_num != '0);
        for (int j = 0; j < 3; j++) begin
            s2_dabs  = r1_d[j][CW] ? -r1_d[j] : r1_d[j];
            s2_dm[j] = s2_dabs[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_f     <= r1_f;
            r2_dm    <= s2_dm;
            r2_dn    <= {r1_d[2][CW], r1_d[1][CW], r1_d[0][CW]};
            r2_cr    <= {r1_d[2][CW] != s2_vz[CW], r1_d[1][CW] != s2_vyneg,
                         r1_d[0][CW] != s2_vx[CW]};
            r2_vmx   <= s2_vxm[CW-1:0];
            r2_vmz   <= s2_vzm[CW-1:0];
            r2_vmy   <= s2_nmag[YW-1:0];
            r2_nm    <= s2_nmag[YW-1:0];
            r2_nneg  <= s2_num[YW];
            r2_nzero <= (s2_num == '0);
        end
    end

    // stage 3: partial products, primary plane test
    logic [2*CW-1:0]      r3_pxx;
    logic [2*CW-1:0]      r3_pzz;
    logic [2*CW-1:0]      r3_pyll;
    logic [CW+HW-1:0]     r3_pylh;
    logic [2*HW-1:0]      r3_pyhh;
    logic [2*CW-1:0]      r3_pdx;
    logic [2*CW-1:0]      r3_pdz;
    logic [2*CW-1:0]      r3_pdyl;
    logic [CW+HW-1:0]     r3_pdyh;
    t_car                 r3_c;
    logic [CW-1:0]        s3_vyl;
    logic [HW-1:0]        s3_vyh;

    assign s3_vyl = r2_vmy[CW-1:0];
    assign s3_vyh = r2_vmy[YW-1:CW];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_pxx   <= r2_vmx * r2_vmx;
            r3_pzz   <= r2_vmz * r2_vmz;
            r3_pyll  <= s3_vyl * s3_vyl;
            r3_pylh  <= s3_vyl * s3_vyh;
            r3_pyhh  <= s3_vyh * s3_vyh;
            r3_pdx   <= r2_dm[0] * r2_vmx;
            r3_pdz   <= r2_dm[2] * r2_vmz;
            r3_pdyl  <= r2_dm[1] * s3_vyl;
            r3_pdyh  <= r2_dm[1] * s3_vyh;
            r3_c.f   <= r2_f;
            r3_c.dm  <= r2_dm;
            r3_c.dn  <= r2_dn;
            r3_c.cr  <= r2_cr;
            r3_c.nm  <= r2_nm;
            r3_c.pok <= (r2_dm[1] != '0) && (r2_nzero || (r2_nneg == r2_dn[1]))
                        && (r2_nm <= YW'(r2_dm[1]));
        end
    end

    // stage 4: assemble the y terms
    logic [2*YW-1:0]      r4_vy2;
    logic [CW+YW-1:0]     r4_pdy;
    logic [2*CW-1:0]      r4_pxx;
    logic [2*CW-1:0]      r4_pzz;
    logic [2*CW-1:0]      r4_pdx;
    logic [2*CW-1:0]      r4_pdz;
    t_car                 r4_c;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_vy2 <= (2*YW)'(r3_pyll) + ((2*YW)'(r3_pylh) << (CW + 1))
                      + ((2*YW)'(r3_pyhh) << (2 * CW));
            r4_pdy <= (CW+YW)'(r3_pdyl) + ((CW+YW)'(r3_pdyh) << CW);
            r4_pxx <= r3_pxx;
            r4_pzz <= r3_pzz;
            r4_pdx <= r3_pdx;
            r4_pdz <= r3_pdz;
            r4_c   <= r3_c;
        end
    end

    // stage 5: |v|^2 and signed dot halves
    logic [SW-1:0]        r5_s;
    logic [PW-1:0]        r5_pos;
    logic [PW-1:0]        r5_neg;
    t_car                 r5_c;
    logic [2:0][PW-1:0]   s5_p;

    assign s5_p = {PW'(r4_pdz), PW'(r4_pdy), PW'(r4_pdx)};

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_s   <= SW'(r4_pxx) + SW'(r4_vy2) + SW'(r4_pzz);
            r5_pos <= (r4_c.cr[0] ? '0 : s5_p[0]) + (r4_c.cr[1] ? '0 : s5_p[1])
                      + (r4_c.cr[2] ? '0 : s5_p[2]);
            r5_neg <= (r4_c.cr[0] ? s5_p[0] : '0) + (r4_c.cr[1] ? s5_p[1] : '0)
                      + (r4_c.cr[2] ? s5_p[2] : '0);
            r5_c   <= r4_c;
        end
    end

    // stage 6: fallback denominator
    logic [SW-1:0]        r6_s;
    logic                 r6_szero;
    logic [PW-1:0]        r6_dd;
    logic                 r6_gt;
    t_car                 r6_c;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_s     <= r5_s;
            r6_szero <= (r5_s == '0);
            r6_dd    <= r5_neg - r5_pos;
            r6_gt    <= (r5_neg > r5_pos);
            r6_c     <= r5_c;
        end
    end

    // stage 7: pick the plane
    rbpi_pkg::t_scl_in    r7_d;
    logic                 s7_fok;

    assign s7_fok = !r6_szero && r6_gt && (r6_s <= SW'(r6_dd));

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r7_d.ok <= r_scene_ready && (r6_c.pok || s7_fok);
            r7_d.nn <= r6_c.pok ? PW'(r6_c.nm) : r6_s[PW-1:0];
            r7_d.dd <= r6_c.pok ? PW'(r6_c.dm[1]) : r6_dd;
            r7_d.f  <= r6_c.f;
            r7_d.dm <= r6_c.dm;
            r7_d.dn <= r6_c.dn;
        end
    end

    // divider steps
    rbpi_pkg::t_scl_st    s_st;

    rbpi_scale u_scale (
        .i_clk (i_clk),
        .i_en  (en[NST-1:rbpi_pkg::NPRE]),
        .i_d   (r7_d),
        .o_st  (s_st)
    );

    // rounding and output register
    rbpi_pkg::t_res       r_out;
    rbpi_pkg::t_res       n_out;

    always_comb begin
        logic [2:0][CW-1:0] pos;
        logic [CW-1:0]      qr;
        for (int j = 0; j < 3; j++) begin
            qr = s_st.q[j] + CW'({s_st.rem[j], 1'b0} >= {1'b0, s_st.dd});
            pos[j] = s_st.dn[j] ? s_st.f[j] - qr : s_st.f[j] + qr;
            if (!s_st.ok) begin
                pos[j] = '0;
            end
        end
        n_out.hit   = s_st.ok;
        n_out.pos_x = pos[0];
        n_out.pos_y = pos[1];
        n_out.pos_z = pos[2];
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_ovld;
    assign o_res.data  = r_out;

`ifndef NO_ASSERTIONS
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en[0] |-> ((&r_vld) && r_ovld))
        else $error("input stalled with a free pipeline slot");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.hit) |->
        (o_res.data.pos_x == '0 && o_res.data.pos_y == '0 && o_res.data.pos_z == '0))
        else $error("miss result carries a nonzero point");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && !r_ovld) |=> r_ovld)
        else $error("finished item not moved to the output register");
`endif

endmodule
